// ===== sv/pmpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// pmpwm_pkg
// Shared types, constants and helpers of the phased multichannel PWM block.
// ----------------------------------------------------------------------------
package pmpwm_pkg;

  localparam int unsigned CHANNELS  = 7;
  localparam int unsigned CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned LED_W     = 7;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned ACC_W     = 17;
  localparam int unsigned BEAT_W    = 3;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW   = $clog2(FIFO_DEPTH);

  localparam logic [CNT_W-1:0] STEP_RESET = 16'd25033;
  localparam logic [CNT_W-1:0] MODULUS    = 16'd65535;
  localparam logic [ACC_W-1:0] ACC_OVER   = 17'd65536;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_K     = 8'h6B;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef enum logic [1:0] {
    JOB_TICK  = 2'd0,
    JOB_DIGIT = 2'd1,
    JOB_CMD   = 2'd2,
    JOB_BAD   = 2'd3
  } job_kind_e;

  typedef enum logic {
    KIND_LINE = 1'b0,
    KIND_CHAR = 1'b1
  } out_kind_e;

  typedef struct packed {
    job_kind_e        kind;
    logic [7:0]       ch;
    logic [LED_W-1:0] lines;
  } job_t;

  typedef struct packed {
    out_kind_e        kind;
    logic [7:0]       tx_char;
    logic [LED_W-1:0] lines;
    logic             last;
  } result_t;

  typedef struct packed {
    logic                 valid;
    logic                 full;
    logic [FIFO_AW:0]     count;
  } fifo_stat_t;

  // Staggered reset phase of channel n: (n * 197) mod 256.
  function automatic logic [CNT_W-1:0] phase_init(int unsigned n);
    return CNT_W'((n * 197) & 255);
  endfunction

  // One result of a queued job, picked by its beat number.
  function automatic result_t result_for(job_t j, logic [BEAT_W-1:0] beat);
    result_t r;
    r.kind    = KIND_CHAR;
    r.tx_char = j.ch;
    r.lines   = j.lines;
    r.last    = 1'b0;
    case (j.kind)
      JOB_TICK: begin
        r.kind    = KIND_LINE;
        r.tx_char = 8'd0;
        r.last    = 1'b1;
      end
      JOB_DIGIT: begin
        r.last = 1'b1;
      end
      JOB_BAD: begin
        if (beat != '0) begin
          r.tx_char = CH_DOT;
          r.last    = 1'b1;
        end
      end
      JOB_CMD: begin
        case (beat)
          3'd0: r.tx_char = j.ch;
          3'd1: r.tx_char = CH_O;
          3'd2: r.tx_char = CH_K;
          3'd3: r.tx_char = CH_CR;
          default: begin
            r.tx_char = CH_LF;
            r.last    = 1'b1;
          end
        endcase
      end
      default: r.last = 1'b1;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/pmpwm_front.sv =====
// ----------------------------------------------------------------------------
// pmpwm_front
// Accepts ticks and characters, updates counters, duties and the number
// accumulator, and hands one classified job per item to the queue.
// ----------------------------------------------------------------------------
module pmpwm_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic                               op_i,
  input  logic [7:0]                         rx_char_i,
  input  logic                               cfg_we_i,
  input  logic [pmpwm_pkg::CNT_W-1:0]        cfg_wdata_i,
  output pmpwm_pkg::job_t                    job_o
);

  logic [pmpwm_pkg::CNT_W-1:0]    step_q;
  logic [pmpwm_pkg::CNT_W-1:0]    phase_q [pmpwm_pkg::CHANNELS];
  logic [pmpwm_pkg::CNT_W-1:0]    phase_d [pmpwm_pkg::CHANNELS];
  logic [pmpwm_pkg::CNT_W-1:0]    duty_q  [pmpwm_pkg::CHANNELS];
  logic [pmpwm_pkg::CNT_W-1:0]    duty_d  [pmpwm_pkg::CHANNELS];
  logic [pmpwm_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic [pmpwm_pkg::CH_W-1:0]     ptr_q, ptr_d;
  logic [pmpwm_pkg::CHANNELS-1:0] line_q, line_d;

  logic [pmpwm_pkg::CNT_W-1:0]    cur;
  logic [pmpwm_pkg::CNT_W:0]      thr;
  logic                           hi;
  logic [7:0]                     lc;
  logic [7:0]                     letter;
  logic [pmpwm_pkg::CNT_W-1:0]    value;
  logic [pmpwm_pkg::ACC_W+3:0]    prod;
  logic                           is_digit;

  always_comb begin
    phase_d = phase_q;
    duty_d  = duty_q;
    acc_d   = acc_q;
    ptr_d   = ptr_q;
    line_d  = line_q;

    cur = phase_q[ptr_q];
    hi  = cur < duty_q[ptr_q];
    thr = {1'b0, pmpwm_pkg::MODULUS} - {1'b0, step_q};

    lc = ((rx_char_i >= pmpwm_pkg::CH_UP_A) && (rx_char_i <= pmpwm_pkg::CH_UP_Z))
         ? rx_char_i + pmpwm_pkg::CASE_OFS : rx_char_i;
    letter   = lc - pmpwm_pkg::CH_A;
    is_digit = (rx_char_i >= pmpwm_pkg::CH_0) && (rx_char_i <= pmpwm_pkg::CH_9);
    value    = acc_q[pmpwm_pkg::ACC_W-1] ? pmpwm_pkg::MODULUS
                                          : acc_q[pmpwm_pkg::CNT_W-1:0];
    prod     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
               + (pmpwm_pkg::ACC_W+4)'(rx_char_i - pmpwm_pkg::CH_0);

    job_o.ch   = rx_char_i;
    job_o.kind = pmpwm_pkg::JOB_BAD;

    if (!op_i) begin
      job_o.kind = pmpwm_pkg::JOB_TICK;
      job_o.ch   = 8'd0;
      for (int n = 0; n < pmpwm_pkg::CHANNELS; n++) begin
        if (ptr_q == pmpwm_pkg::CH_W'(n)) begin
          line_d[n] = hi;
          // Wrap modulo 65535 without a divider.
          if ({1'b0, cur} >= thr) begin
            phase_d[n] = pmpwm_pkg::CNT_W'({1'b0, cur} - thr);
          end else begin
            phase_d[n] = cur + step_q;
          end
        end
      end
      if (ptr_q == pmpwm_pkg::CH_W'(pmpwm_pkg::CHANNELS - 1)) begin
        ptr_d = '0;
      end else begin
        ptr_d = ptr_q + 1'b1;
      end
    end else if (is_digit) begin
      job_o.kind = pmpwm_pkg::JOB_DIGIT;
      if (acc_q[pmpwm_pkg::ACC_W-1] || (prod > (pmpwm_pkg::ACC_W+4)'(pmpwm_pkg::ACC_OVER))) begin
        acc_d = pmpwm_pkg::ACC_OVER;
      end else begin
        acc_d = pmpwm_pkg::ACC_W'(prod);
      end
    end else if ((lc >= pmpwm_pkg::CH_A) && (lc <= pmpwm_pkg::CH_G)) begin
      job_o.kind = pmpwm_pkg::JOB_CMD;
      acc_d      = '0;
      for (int n = 0; n < pmpwm_pkg::CHANNELS; n++) begin
        if (letter == 8'(n)) begin
          duty_d[n] = value;
        end
      end
    end else if (lc == pmpwm_pkg::CH_S) begin
      job_o.kind = pmpwm_pkg::JOB_CMD;
      acc_d      = '0;
      for (int n = 0; n < pmpwm_pkg::CHANNELS; n++) begin
        duty_d[n] = value;
      end
    end else if (lc == pmpwm_pkg::CH_M) begin
      job_o.kind = pmpwm_pkg::JOB_CMD;
      acc_d      = '0;
    end else if (lc == pmpwm_pkg::CH_O) begin
      job_o.kind = pmpwm_pkg::JOB_CMD;
      acc_d      = '0;
      for (int n = 0; n < pmpwm_pkg::CHANNELS; n++) begin
        duty_d[n] = '0;
      end
    end

    // Snapshot of the lines after this item.
    job_o.lines = pmpwm_pkg::LED_W'(line_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= pmpwm_pkg::STEP_RESET;
      acc_q  <= '0;
      ptr_q  <= '0;
      line_q <= '0;
      for (int n = 0; n < pmpwm_pkg::CHANNELS; n++) begin
        phase_q[n] <= pmpwm_pkg::phase_init(n);
        duty_q[n]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        acc_q   <= acc_d;
        ptr_q   <= ptr_d;
        line_q  <= line_d;
        phase_q <= phase_d;
        duty_q  <= duty_d;
      end
    end
  end

endmodule

// ===== sv/pmpwm_fifo.sv =====
// ----------------------------------------------------------------------------
// pmpwm_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module pmpwm_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pmpwm_pkg::job_t       push_job_i,
  input  logic                  pop_i,
  output pmpwm_pkg::job_t       head_o,
  output pmpwm_pkg::fifo_stat_t stat_o
);

  pmpwm_pkg::job_t                 mem_q [pmpwm_pkg::FIFO_DEPTH];
  logic [pmpwm_pkg::FIFO_AW-1:0]   wr_q, rd_q;
  logic [pmpwm_pkg::FIFO_AW:0]     count_q, count_d;

  assign head_o       = mem_q[rd_q];
  assign stat_o.valid = count_q != '0;
  assign stat_o.full  = count_q == (pmpwm_pkg::FIFO_AW+1)'(pmpwm_pkg::FIFO_DEPTH);
  assign stat_o.count = count_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

// ===== sv/pmpwm_back.sv =====
// ----------------------------------------------------------------------------
// pmpwm_back
// Expands queued jobs into result transactions through an output register.
// ----------------------------------------------------------------------------
module pmpwm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pmpwm_pkg::job_t       head_i,
  input  logic                  head_valid_i,
  output logic                  pop_o,
  output logic                  busy_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pmpwm_pkg::result_t    res_o
);

  logic                          busy_q, busy_d;
  pmpwm_pkg::job_t               job_q, job_d;
  logic [pmpwm_pkg::BEAT_W-1:0]  beat_q, beat_d;
  logic                          out_valid_q, out_valid_d;
  pmpwm_pkg::result_t            res_q, res_d;

  pmpwm_pkg::job_t               src_job;
  logic [pmpwm_pkg::BEAT_W-1:0]  src_beat;
  logic                          load;
  logic                          have;

  assign load   = !out_valid_q || !out_stall_i;
  assign have   = busy_q || head_valid_i;
  assign pop_o  = load && !busy_q && head_valid_i;
  assign busy_o = busy_q;

  always_comb begin
    src_job     = busy_q ? job_q : head_i;
    src_beat    = busy_q ? beat_q : '0;
    busy_d      = busy_q;
    job_d       = job_q;
    beat_d      = beat_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (load) begin
      out_valid_d = have;
      if (have) begin
        res_d  = pmpwm_pkg::result_for(src_job, src_beat);
        busy_d = !res_d.last;
        job_d  = src_job;
        beat_d = src_beat + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    job_q <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      beat_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      beat_q      <= beat_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== sv/phased_multichannel_pwm_with_commands.sv =====
// An item's first result passes through the job queue and the output register.
// Throughput: one result per cycle while the output is not stalled; a tick or a
// digit gives one result, a command character five, any other character two.
// A four-entry job queue lets ticks keep entering while characters drain.
// Reset: asynchronous, active low; phases start staggered, duties and the
// number cleared, count step back to 25033. No clearing pass.
// ----------------------------------------------------------------------------
// phased_multichannel_pwm_with_commands
// Round-robin phased PWM for seven LED channels with a character command
// parser that echoes input and acknowledges commands.
// ----------------------------------------------------------------------------
module phased_multichannel_pwm_with_commands (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic [7:0]                        rx_char_i,
  input  logic                              cfg_we_i,
  input  logic [pmpwm_pkg::CNT_W-1:0]       cfg_wdata_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              kind_o,
  output logic [7:0]                        tx_char_o,
  output logic [pmpwm_pkg::LED_W-1:0]       led_lines_o,
  output logic                              last_o
);

  pmpwm_pkg::job_t       new_job;
  pmpwm_pkg::job_t       head_job;
  pmpwm_pkg::fifo_stat_t fifo_stat;
  pmpwm_pkg::result_t    res;
  logic                  accept;
  logic                  pop;
  logic                  busy;

  assign in_stall_o = fifo_stat.full;
  assign accept     = in_valid_i && !fifo_stat.full;

  pmpwm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (op_i),
    .rx_char_i   (rx_char_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .job_o       (new_job)
  );

  pmpwm_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_job_i (new_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .stat_o     (fifo_stat)
  );

  pmpwm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_job),
    .head_valid_i (fifo_stat.valid),
    .pop_o        (pop),
    .busy_o       (busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res)
  );

  assign kind_o      = res.kind;
  assign tx_char_o   = res.tx_char;
  assign led_lines_o = res.lines;
  assign last_o      = res.last;

  // Queue never overfills.
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.count <= (pmpwm_pkg::FIFO_AW+1)'(pmpwm_pkg::FIFO_DEPTH))
    else $error("job queue count beyond depth");

  // A line update is always a single, final result.
  a_tick_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == pmpwm_pkg::KIND_LINE)) |-> last_o)
    else $error("line update not marked last");

  // A multi-result sequence continues without gaps.
  a_seq_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> out_valid_o)
    else $error("result sequence broken");

  // Nothing is popped while a job is still being expanded.
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !pop)
    else $error("queue popped during expansion");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the phased multichannel PWM with command parser.
// A queue of ticks and command characters feeds a clocked driver, and a
// clocked monitor compares every output transaction with a built-in
// prediction of lines, phase counters, duties and the number parser.
// The count step is rewritten between phases that vary sender and receiver
// idling.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_CHAR     = 1'b1;
  localparam int   MAX_REPORTS = 10;
  localparam int   PHASES      = 8;
  localparam int   PHASE_ITEMS = 50;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
  } rx_item_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          op_i        = OP_TICK;
  logic [7:0]                    rx_char_i   = '0;
  logic                          cfg_we_i    = 1'b0;
  logic [pmpwm_pkg::CNT_W-1:0]   cfg_wdata_i = '0;
  logic                          out_stall_i = 1'b0;
  logic                          in_stall_o;
  logic                          out_valid_o;
  logic                          kind_o;
  logic [7:0]                    tx_char_o;
  logic [pmpwm_pkg::LED_W-1:0]   led_lines_o;
  logic                          last_o;

  // Predicted block state
  logic [pmpwm_pkg::CNT_W-1:0]   phase_cnt [pmpwm_pkg::CHANNELS];
  logic [pmpwm_pkg::CNT_W-1:0]   duty [pmpwm_pkg::CHANNELS];
  logic [pmpwm_pkg::ACC_W-1:0]   num_acc;
  int unsigned                   chan_ptr;
  logic [pmpwm_pkg::LED_W-1:0]   line_reg;
  logic [pmpwm_pkg::CNT_W-1:0]   step_reg;

  pmpwm_pkg::result_t            line_tx_q [$];
  rx_item_t                      send_q [$];
  rx_item_t                      cur_item;

  int                   in_idle_pct   = 0;
  int                   out_stall_pct = 0;
  int                   mismatches    = 0;
  int                   beats_checked = 0;
  int                   ticks_sent    = 0;
  int                   chars_sent    = 0;

  phased_multichannel_pwm_with_commands DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .rx_char_i   (rx_char_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .tx_char_o   (tx_char_o),
    .led_lines_o (led_lines_o),
    .last_o      (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic pmpwm_pkg::result_t char_beat(logic [7:0] c, logic lst);
    pmpwm_pkg::result_t r;
    r.kind    = pmpwm_pkg::KIND_CHAR;
    r.tx_char = c;
    r.lines   = line_reg;
    r.last    = lst;
    return r;
  endfunction

  // Advance the predicted state by one accepted transaction and queue its results.
  task automatic pwm_cmd_step(rx_item_t it);
    int unsigned                 p;
    int unsigned                 acc_next;
    logic [pmpwm_pkg::CNT_W-1:0] c;
    logic [pmpwm_pkg::CNT_W-1:0] thr;
    logic [pmpwm_pkg::CNT_W-1:0] val;
    logic [7:0]                  lc;
    logic                        is_cmd;
    pmpwm_pkg::result_t          r;
    if (it.op == OP_TICK) begin
      p = (chan_ptr >= pmpwm_pkg::CHANNELS) ? 0 : chan_ptr;
      c = phase_cnt[p];
      line_reg[p] = (c < duty[p]);
      // modulo-65535 add; step 0 or 65535 leaves the counter in place
      thr = pmpwm_pkg::MODULUS - step_reg;
      c = (c >= thr) ? c - thr : c + step_reg;
      phase_cnt[p] = c;
      chan_ptr = (p + 1 >= pmpwm_pkg::CHANNELS) ? 0 : p + 1;
      r.kind    = pmpwm_pkg::KIND_LINE;
      r.tx_char = '0;
      r.lines   = line_reg;
      r.last    = 1'b1;
      line_tx_q.push_back(r);
    end else if (it.ch >= pmpwm_pkg::CH_0 && it.ch <= pmpwm_pkg::CH_9) begin
      if (num_acc >= pmpwm_pkg::ACC_OVER) begin
        num_acc = pmpwm_pkg::ACC_OVER;
      end else begin
        acc_next = int'(num_acc) * 10 + int'(it.ch - pmpwm_pkg::CH_0);
        if (acc_next > pmpwm_pkg::ACC_OVER) acc_next = pmpwm_pkg::ACC_OVER;
        num_acc = pmpwm_pkg::ACC_W'(acc_next);
      end
      line_tx_q.push_back(char_beat(it.ch, 1'b1));
    end else begin
      lc = (it.ch >= pmpwm_pkg::CH_UP_A && it.ch <= pmpwm_pkg::CH_UP_Z)
           ? it.ch + pmpwm_pkg::CASE_OFS : it.ch;
      val = (num_acc >= pmpwm_pkg::ACC_OVER) ? pmpwm_pkg::MODULUS
                                             : num_acc[pmpwm_pkg::CNT_W-1:0];
      is_cmd = 1'b1;
      if (lc >= pmpwm_pkg::CH_A && lc <= pmpwm_pkg::CH_G) begin
        p = int'(lc - pmpwm_pkg::CH_A);
        if (p < pmpwm_pkg::CHANNELS) duty[p] = val;
        num_acc = '0;
      end else if (lc == pmpwm_pkg::CH_S) begin
        foreach (duty[n]) duty[n] = val;
        num_acc = '0;
      end else if (lc == pmpwm_pkg::CH_M) begin
        num_acc = '0;
      end else if (lc == pmpwm_pkg::CH_O) begin
        foreach (duty[n]) duty[n] = '0;
        num_acc = '0;
      end else begin
        is_cmd = 1'b0;
      end
      line_tx_q.push_back(char_beat(it.ch, 1'b0));
      if (!is_cmd) begin
        line_tx_q.push_back(char_beat(pmpwm_pkg::CH_DOT, 1'b1));
      end else begin
        line_tx_q.push_back(char_beat(pmpwm_pkg::CH_O, 1'b0));
        line_tx_q.push_back(char_beat(pmpwm_pkg::CH_K, 1'b0));
        line_tx_q.push_back(char_beat(pmpwm_pkg::CH_CR, 1'b0));
        line_tx_q.push_back(char_beat(pmpwm_pkg::CH_LF, 1'b1));
      end
    end
  endtask

  task automatic push_tick();
    rx_item_t it;
    it.op = OP_TICK;
    it.ch = 8'($urandom);
    send_q.push_back(it);
  endtask

  task automatic push_char(logic [7:0] c);
    rx_item_t it;
    it.op = OP_CHAR;
    it.ch = c;
    send_q.push_back(it);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  // Mostly bursts of ticks and well-formed number+letter commands, some noise.
  task automatic queue_random_mix(int n);
    int         made;
    int         k;
    int         nd;
    int         idx;
    logic [7:0] letter;
    made = 0;
    while (made < n) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        nd = $urandom_range(1, 8);
        repeat (nd) push_tick();
        made += nd;
      end else if (k < 88) begin
        nd = $urandom_range(0, 6);
        repeat (nd) push_char(pmpwm_pkg::CH_0 + 8'($urandom_range(0, 9)));
        idx = $urandom_range(0, 9);
        letter = (idx < 7)  ? pmpwm_pkg::CH_A + 8'(idx) :
                 (idx == 7) ? pmpwm_pkg::CH_S :
                 (idx == 8) ? pmpwm_pkg::CH_M : pmpwm_pkg::CH_O;
        if ($urandom_range(0, 1) == 1) letter = letter - pmpwm_pkg::CASE_OFS;
        push_char(letter);
        made += nd + 1;
      end else begin
        push_char(8'($urandom_range(0, 255)));
        made += 1;
      end
    end
  endtask

  // Sample at the falling edge so queue and valid updates have settled.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (send_q.size() != 0 || in_valid_i || line_tx_q.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        pwm_cmd_step(cur_item);
        if (cur_item.op == OP_TICK) ticks_sent++;
        else chars_sent++;
      end
      // hold a stalled transaction; otherwise offer the next one or idle
      if (!in_valid_i || !in_stall_o) begin
        if (send_q.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          cur_item = send_q.pop_front();
          in_valid_i <= 1'b1;
          op_i <= cur_item.op;
          rx_char_i <= cur_item.ch;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    pmpwm_pkg::result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (line_tx_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("tb: unexpected transaction kind=%0d tx=%02h lines=%02h last=%0d",
                     kind_o, tx_char_o, led_lines_o, last_o);
        end else begin
          want = line_tx_q.pop_front();
          beats_checked++;
          if (kind_o !== want.kind || tx_char_o !== want.tx_char ||
              led_lines_o !== want.lines || last_o !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"tb: mismatch at %0t: exp kind=%0d tx=%02h lines=%02h last=%0d,",
                        " got kind=%0d tx=%02h lines=%02h last=%0d"},
                       $realtime, want.kind, want.tx_char, want.lines, want.last,
                       kind_o, tx_char_o, led_lines_o, last_o);
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < out_stall_pct);
    end
  end

  initial begin
    logic [pmpwm_pkg::CNT_W-1:0] steps [PHASES];
    foreach (phase_cnt[n]) begin
      phase_cnt[n] = pmpwm_pkg::CNT_W'((n * 197) & 255);
      duty[n] = '0;
    end
    num_acc  = '0;
    chan_ptr = 0;
    line_reg = '0;
    step_reg = pmpwm_pkg::STEP_RESET;
    steps[0] = 16'd1;
    steps[1] = 16'd65534;
    steps[2] = 16'd0;
    steps[3] = 16'd65535;
    steps[4] = 16'd40502;
    steps[5] = 16'($urandom_range(1, 65534));
    steps[6] = 16'($urandom_range(1, 65534));
    steps[7] = 16'($urandom_range(1, 65534));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full duty on channel 0, saturated number on channel 6, then
    // consume, set-all, clear and two non-command characters
    push_tick();
    push_text("65535a");
    push_text("65536G");
    repeat (7) push_tick();
    push_text("Mso");
    push_char(8'hFF);
    push_char(pmpwm_pkg::CH_9 + 8'd1);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_wdata_i <= steps[ph];
      step_reg = steps[ph];
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      case (ph % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 86; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 86; end
        default: begin in_idle_pct = 25; out_stall_pct = 25; end
      endcase
      queue_random_mix(PHASE_ITEMS);
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("tb: %0d ticks and %0d characters over %0d count steps, %0d results checked",
             ticks_sent, chars_sent, PHASES + 1, beats_checked);
    $display("tb: %0d mismatching or unexpected transactions", mismatches);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== phased_multichannel_pwm_with_commands.f =====
sv/pmpwm_pkg.sv
sv/pmpwm_front.sv
sv/pmpwm_fifo.sv
sv/pmpwm_back.sv
sv/phased_multichannel_pwm_with_commands.sv
test/tb.sv
